// ===== sv/input_current_limit_ramp_assert.svh =====
// Assertion macros for the input current limit ramp.
`ifndef INPUT_CURRENT_LIMIT_RAMP_ASSERT_SVH
`define INPUT_CURRENT_LIMIT_RAMP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ICLR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ICLR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/icl_pkg.sv =====
// Types, constants and the current ladder for the input current limit ramp.
package icl_pkg;

  localparam int REQ_W    = 13;
  localparam int MV_W     = 14;
  localparam int MARGIN_W = 8;
  localparam int LVL_W    = 3;
  localparam int MA_W     = 12;
  localparam int IDX_W    = 2;

  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;

  localparam logic [MV_W-1:0]     THR_RESET    = 14'd4500;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd50;
  localparam logic [MV_W-1:0]     ABSENT_RESET = 14'd2000;

  localparam logic [REQ_W-1:0] REQ_500  = 13'd500;
  localparam logic [REQ_W-1:0] REQ_900  = 13'd900;
  localparam logic [REQ_W-1:0] REQ_1200 = 13'd1200;
  localparam logic [REQ_W-1:0] REQ_1500 = 13'd1500;
  localparam logic [REQ_W-1:0] REQ_2000 = 13'd2000;
  localparam logic [REQ_W-1:0] REQ_3000 = 13'd3000;

  typedef enum logic [S_USER_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_FORGET  = 2'd2
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MARGIN    = 2'd1,
    REG_BB_WORK   = 2'd2,
    REG_ABSENT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]     thr;
    logic [MARGIN_W-1:0] margin;
    logic                bb_work;
    logic [MV_W-1:0]     absent;
  } cfg_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [REQ_W-1:0] req;
    logic [MV_W-1:0]  vbus;
    logic             bb;
    logic             susp;
  } item_t;

  typedef struct packed {
    logic [REQ_W-1:0] rem_req;
    logic             rem_valid;
    logic             ramping;
    logic [LVL_W-1:0] level;
    logic [REQ_W-1:0] target;
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [MA_W-1:0]  limit;
    logic             fin;
    logic             cbv;
    logic             scp;
  } result_t;

  function automatic logic [MA_W-1:0] ladder_ma(input logic [LVL_W-1:0] lvl);
    logic [MA_W-1:0] ma;
    case (lvl)
      3'd0:    ma = 12'd300;
      3'd1:    ma = 12'd500;
      3'd2:    ma = 12'd900;
      3'd3:    ma = 12'd1200;
      3'd4:    ma = 12'd1500;
      3'd5:    ma = 12'd1750;
      3'd6:    ma = 12'd2000;
      default: ma = 12'd3000;
    endcase
    return ma;
  endfunction

endpackage

// ===== sv/icl_step.sv =====
// Next-state and result logic for one ramp event.
module icl_step (
  input  icl_pkg::cfg_t    cfg,
  input  icl_pkg::state_t  cur,
  input  icl_pkg::item_t   item,
  output icl_pkg::state_t  nxt,
  output icl_pkg::result_t res
);
  import icl_pkg::*;

  logic [LVL_W-1:0] lvl;
  logic [LVL_W-1:0] back_lvl;
  logic [MV_W:0]    thr_eff;
  logic             end_hit;
  logic [LVL_W-1:0] end_lvl;

  assign lvl = cur.level;

  always_comb begin
    case (lvl)
      3'd0, 3'd1:       back_lvl = lvl;
      3'd4, 3'd5, 3'd6: back_lvl = lvl - 3'd2;
      default:          back_lvl = lvl - 3'd1;
    endcase
  end

  always_comb begin
    thr_eff = {1'b0, cfg.thr};
    if (lvl == 3'd4 || lvl == 3'd5) begin
      thr_eff = {1'b0, cfg.thr} + {{(MV_W + 1 - MARGIN_W){1'b0}}, cfg.margin};
    end
  end

  always_comb begin
    end_hit = 1'b0;
    end_lvl = lvl;
    case (lvl)
      3'd1: end_hit = cur.target < REQ_900;
      3'd2: end_hit = cur.target < REQ_1200;
      3'd4: begin
        if (cur.target < REQ_1500) begin
          end_hit = 1'b1;
          end_lvl = 3'd3;
        end else if (cur.target < REQ_2000) begin
          end_hit = 1'b1;
        end
      end
      3'd6: end_hit = cur.target < REQ_3000;
      3'd7: end_hit = 1'b1;
      default: end_hit = 1'b0;
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (item.cmd)
      CMD_FORGET: nxt.rem_valid = 1'b0;
      CMD_REQUEST: begin
        if (!(cur.rem_valid && item.req == cur.rem_req)) begin
          nxt.rem_req   = item.req;
          nxt.rem_valid = 1'b1;
          nxt.target    = item.req;
          res.valid     = 1'b1;
          if (item.req < REQ_500) begin
            nxt.level   = 3'd0;
            nxt.ramping = 1'b0;
            res.fin     = 1'b1;
          end else begin
            nxt.level   = 3'd1;
            nxt.ramping = 1'b1;
            res.cbv     = item.bb;
          end
        end
      end
      CMD_SAMPLE: begin
        if (!cur.ramping) begin
          if (item.vbus < cfg.absent) nxt.rem_valid = 1'b0;
        end else begin
          res.valid   = 1'b1;
          res.fin     = 1'b1;
          nxt.ramping = 1'b0;
          if (lvl == 3'd0) begin
            nxt.level = 3'd0;
          end else if (item.bb) begin
            nxt.level = back_lvl;
            res.cbv   = cfg.bb_work;
          end else if (lvl >= 3'd2 && item.susp) begin
            nxt.level = back_lvl;
            res.scp   = 1'b1;
          end else begin
            if (item.vbus < cfg.absent) nxt.rem_valid = 1'b0;
            if ({1'b0, item.vbus} < thr_eff) begin
              nxt.level = back_lvl;
            end else if (end_hit) begin
              nxt.level = end_lvl;
            end else begin
              nxt.level   = lvl + 3'd1;
              nxt.ramping = 1'b1;
              res.fin     = 1'b0;
            end
          end
        end
      end
      default: nxt = cur;
    endcase
    res.level = nxt.level;
    res.limit = ladder_ma(nxt.level);
  end

endmodule

// ===== sv/input_current_limit_ramp.sv =====
// Top level of the input current limit ramp: channels, registers and checks.
// Usage:
//   s_* channel carries one event per transfer; s_tuser is the command
//   (request, settle sample, forget), s_tdata the request, bus voltage and
//   the boost-back and suspend flags.
//   m_* channel returns at most one result per event: ladder level, limit,
//   and the boost-vote and suspend-pulse requests; m_tlast is set when the
//   ramp has ended, clear while it waits for the next settle sample.
//   cfg_* writes one register per transfer; always ready, write only when idle.
// Datapath: an event is held in the input register, is evaluated in
//   one pass and its result, if any, lands in the result register, which
//   drives m_*.
//   Throughput is one event per cycle while the result is not stalled.
// Stalls: while m_tready is low the result holds; one more event is taken
//   into the input register, then s_tready drops until the result moves.
// Reset: rst clears both registers, the ramp state and loads the default
//   thresholds (4500 mV collapse, 50 mV margin, 2000 mV absent bus).
`include "input_current_limit_ramp_assert.svh"

module input_current_limit_ramp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // requested_ma[12:0], vbus_mv[26:13], boost_back[27], suspended[28], zero pad
  input  logic [icl_pkg::S_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [icl_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // level[2:0], limit_ma[14:3], clear_boost_vote[15], suspend_clear_pulse[16], zero pad
  output logic [icl_pkg::M_DATA_W-1:0]  m_tdata,
  // final_res
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [icl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [icl_pkg::MV_W-1:0]      cfg_data
);
  import icl_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   in_item;
  logic    in_valid;
  result_t res_next;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr     <= THR_RESET;
      cfg.margin  <= MARGIN_RESET;
      cfg.bb_work <= 1'b0;
      cfg.absent  <= ABSENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: cfg.thr     <= cfg_data;
        REG_MARGIN:    cfg.margin  <= cfg_data[MARGIN_W-1:0];
        REG_BB_WORK:   cfg.bb_work <= cfg_data[0];
        REG_ABSENT:    cfg.absent  <= cfg_data;
        default:       cfg.thr     <= cfg.thr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd  <= cmd_t'(s_tuser);
      in_item.req  <= s_tdata[REQ_W-1:0];
      in_item.vbus <= s_tdata[REQ_W+MV_W-1:REQ_W];
      in_item.bb   <= s_tdata[REQ_W+MV_W];
      in_item.susp <= s_tdata[REQ_W+MV_W+1];
    end
  end

  icl_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (in_item),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_next.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_next.valid) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(M_DATA_W - LVL_W - MA_W - 2){1'b0}}, res.scp, res.cbv, res.limit,
                    res.level};
  assign m_tlast = res.fin;

  `ICLR_ASSERT_NOW(a_ramp_level, clk, rst, state.ramping, state.level != 3'd0,
                   "ramp active at the bottom ladder level")
  `ICLR_ASSERT_NOW(a_open_result_level, clk, rst, m_tvalid && !m_tlast,
                   m_tdata[LVL_W-1:0] != 3'd0, "non-final result at the bottom level")
  `ICLR_ASSERT_NEXT(a_hold_pending, clk, rst, in_valid && m_tvalid && !m_tready,
                    in_valid, "pending event dropped while result stalled")
  `ICLR_ASSERT_NOW(a_limit_matches, clk, rst, m_tvalid,
                   m_tdata[LVL_W+MA_W-1:LVL_W] == ladder_ma(m_tdata[LVL_W-1:0]),
                   "limit does not match ladder level")

endmodule

// ===== tb/icl_ramp_checker.sv =====
// Checker for the input current limit ramp: predicts each result and compares it.
module icl_ramp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [icl_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [icl_pkg::S_USER_W-1:0]  s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [icl_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          m_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [icl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [icl_pkg::MV_W-1:0]      cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import icl_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [MA_W-1:0]  limit_ma;
    logic             done;
    logic             cbv;
    logic             scp;
  } ramp_step_t;

  logic [MV_W-1:0]     thr_mv;
  logic [MARGIN_W-1:0] margin_mv;
  logic                bb_work;
  logic [MV_W-1:0]     absent_mv;

  logic [REQ_W-1:0] mem_req;
  logic             mem_valid;
  logic             active;
  logic [LVL_W-1:0] cur_lvl;
  logic [REQ_W-1:0] goal_ma;

  ramp_step_t pending_steps[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [MA_W-1:0] rung_ma(input logic [LVL_W-1:0] l);
    logic [MA_W-1:0] ma;
    case (l)
      3'd0:    ma = 12'd300;
      3'd1:    ma = 12'd500;
      3'd2:    ma = 12'd900;
      3'd3:    ma = 12'd1200;
      3'd4:    ma = 12'd1500;
      3'd5:    ma = 12'd1750;
      3'd6:    ma = 12'd2000;
      default: ma = 12'd3000;
    endcase
    return ma;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic push_step(input logic [LVL_W-1:0] l, input logic d, input logic c,
                           input logic s);
    ramp_step_t st;
    st.level    = l;
    st.limit_ma = rung_ma(l);
    st.done     = d;
    st.cbv      = c;
    st.scp      = s;
    pending_steps.push_back(st);
  endtask

  task automatic settle_at(input logic [LVL_W-1:0] l, input logic c, input logic s);
    cur_lvl = l;
    active  = 1'b0;
    push_step(l, 1'b1, c, s);
  endtask

  task automatic predict_event(input logic [S_USER_W-1:0] cmd, input logic [REQ_W-1:0] req,
                               input logic [MV_W-1:0] vbus, input logic bb, input logic susp);
    logic [LVL_W-1:0] lv;
    logic [LVL_W-1:0] drop;
    logic [MV_W:0]    sag_mv;
    case (cmd)
      CMD_FORGET: mem_valid = 1'b0;
      CMD_REQUEST: begin
        if (!(mem_valid && req == mem_req)) begin
          mem_req   = req;
          mem_valid = 1'b1;
          goal_ma   = req;
          if (req < REQ_500) begin
            settle_at(3'd0, 1'b0, 1'b0);
          end else begin
            cur_lvl = 3'd1;
            active  = 1'b1;
            push_step(3'd1, 1'b0, bb, 1'b0);
          end
        end
      end
      CMD_SAMPLE: begin
        if (!active) begin
          if (vbus < absent_mv) mem_valid = 1'b0;
        end else if (cur_lvl == 3'd0) begin
          settle_at(3'd0, 1'b0, 1'b0);
        end else begin
          lv = cur_lvl;
          if (lv == 3'd1) drop = 3'd0;
          else if (lv >= 3'd4 && lv <= 3'd6) drop = 3'd2;
          else drop = 3'd1;
          if (bb) begin
            settle_at(lv - drop, bb_work, 1'b0);
          end else if (lv >= 3'd2 && susp) begin
            settle_at(lv - drop, 1'b0, 1'b1);
          end else begin
            if (vbus < absent_mv) mem_valid = 1'b0;
            sag_mv = {1'b0, thr_mv};
            if (lv == 3'd4 || lv == 3'd5) sag_mv = sag_mv + margin_mv;
            if ({1'b0, vbus} < sag_mv) settle_at(lv - drop, 1'b0, 1'b0);
            else if (lv == 3'd1 && goal_ma < REQ_900) settle_at(3'd1, 1'b0, 1'b0);
            else if (lv == 3'd2 && goal_ma < REQ_1200) settle_at(3'd2, 1'b0, 1'b0);
            else if (lv == 3'd4 && goal_ma < REQ_1500) settle_at(3'd3, 1'b0, 1'b0);
            else if (lv == 3'd4 && goal_ma < REQ_2000) settle_at(3'd4, 1'b0, 1'b0);
            else if (lv == 3'd6 && goal_ma < REQ_3000) settle_at(3'd6, 1'b0, 1'b0);
            else if (lv == 3'd7) settle_at(3'd7, 1'b0, 1'b0);
            else begin
              cur_lvl = lv + 3'd1;
              push_step(cur_lvl, 1'b0, 1'b0, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    ramp_step_t want;
    if (pending_steps.size() == 0) begin
      flag_mismatch("unexpected result", -1, int'(m_tdata));
    end else begin
      want = pending_steps.pop_front();
      if (m_tdata[2:0] !== want.level)
        flag_mismatch("level", int'(want.level), int'(m_tdata[2:0]));
      if (m_tdata[14:3] !== want.limit_ma)
        flag_mismatch("limit_ma", int'(want.limit_ma), int'(m_tdata[14:3]));
      if (m_tlast !== want.done)
        flag_mismatch("final_res", int'(want.done), int'(m_tlast));
      if (m_tdata[15] !== want.cbv)
        flag_mismatch("clear_boost_vote", int'(want.cbv), int'(m_tdata[15]));
      if (m_tdata[16] !== want.scp)
        flag_mismatch("suspend_clear_pulse", int'(want.scp), int'(m_tdata[16]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_mv    = THR_RESET;
      margin_mv = MARGIN_RESET;
      bb_work   = 1'b0;
      absent_mv = ABSENT_RESET;
      mem_req   = '0;
      mem_valid = 1'b0;
      active    = 1'b0;
      cur_lvl   = '0;
      goal_ma   = '0;
      pending_steps.delete();
    end else begin
      // a result always leaves after its event was taken, so pop first
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_mv    = cfg_data;
          REG_MARGIN:    margin_mv = cfg_data[MARGIN_W-1:0];
          REG_BB_WORK:   bb_work   = cfg_data[0];
          REG_ABSENT:    absent_mv = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_event(s_tuser, s_tdata[12:0], s_tdata[26:13], s_tdata[27], s_tdata[28]);
    end
    outstanding <= pending_steps.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the input current limit ramp: stimulus, config phases and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icl_pkg::*;

  localparam logic [S_USER_W-1:0] CMD_RESERVED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [MV_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;

  int s_idle = 0;
  int m_idle = 0;
  int thr_set = 4500;
  int margin_set = 50;
  logic [REQ_W-1:0] last_req = '0;

  always #10 clk = ~clk;

  input_current_limit_ramp i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  icl_ramp_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= m_idle);
  end

  task automatic send_ev(input logic [S_USER_W-1:0] cmd, input logic [REQ_W-1:0] req,
                         input logic [MV_W-1:0] vbus, input logic bb, input logic susp);
    while ($urandom_range(99) < s_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, susp, bb, vbus, req};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [MV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int margin, input logic [MV_W-1:0] bbw,
                            input int absent);
    thr_set    = thr;
    margin_set = margin & 32'hff;
    write_reg(REG_THRESHOLD, thr[MV_W-1:0]);
    write_reg(REG_MARGIN, margin[MV_W-1:0]);
    write_reg(REG_BB_WORK, bbw);
    write_reg(REG_ABSENT, absent[MV_W-1:0]);
  endtask

  // hold the sender until every result is back, then let in-flight silent events clear
  task automatic drain();
    int guard;
    s_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] boundary_req();
    logic [REQ_W-1:0] r;
    case ($urandom_range(11))
      0:       r = 13'd499;
      1:       r = 13'd500;
      2:       r = 13'd899;
      3:       r = 13'd900;
      4:       r = 13'd1199;
      5:       r = 13'd1200;
      6:       r = 13'd1499;
      7:       r = 13'd1500;
      8:       r = 13'd1999;
      9:       r = 13'd2000;
      10:      r = 13'd2999;
      default: r = 13'd3000;
    endcase
    return r;
  endfunction

  task automatic send_random();
    int pick;
    int v;
    logic [S_USER_W-1:0] c;
    logic [REQ_W-1:0]    r;
    logic [MV_W-1:0]     vb;
    logic                bb;
    logic                su;
    pick = $urandom_range(99);
    r    = REQ_W'($urandom);
    vb   = MV_W'($urandom);
    bb   = ($urandom_range(99) < 6);
    su   = ($urandom_range(99) < 8);
    if (pick < 14) begin
      c = CMD_REQUEST;
      case ($urandom_range(3))
        0, 1:    r = boundary_req();
        2:       r = last_req;
        default: ;
      endcase
      last_req = r;
    end else if (pick < 88) begin
      c = CMD_SAMPLE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: v = thr_set + margin_set + $urandom_range(3000);
        6, 7, 8:          v = thr_set - 3 + $urandom_range(margin_set + 6);
        default:          v = $urandom_range(16383);
      endcase
      if (v < 0) v = 0;
      if (v > 16383) v = 16383;
      vb = v[MV_W-1:0];
    end else if (pick < 96) begin
      c = CMD_FORGET;
    end else begin
      c = CMD_RESERVED;
    end
    send_ev(c, r, vb, bb, su);
  endtask

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    s_idle = 26;
    m_idle = 55;

    // directed part, reset register values
    send_ev(CMD_SAMPLE, 13'd0, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_RESERVED, 13'h1fff, 14'h3fff, 1'b1, 1'b1);
    send_ev(CMD_REQUEST, 13'h1fff, 14'd0, 1'b1, 1'b0);
    send_ev(CMD_REQUEST, 13'h1fff, 14'd0, 1'b0, 1'b0);
    repeat (7) send_ev(CMD_SAMPLE, 13'd0, 14'h3fff, 1'b0, 1'b0);
    send_ev(CMD_FORGET, 13'd0, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_REQUEST, 13'h1fff, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_SAMPLE, 13'd0, 14'h3fff, 1'b1, 1'b0);
    send_ev(CMD_REQUEST, 13'd0, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_REQUEST, 13'd499, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_REQUEST, 13'd500, 14'd0, 1'b0, 1'b0);
    send_ev(CMD_SAMPLE, 13'd0, 14'd4499, 1'b0, 1'b0);
    send_ev(CMD_REQUEST, 13'd1750, 14'd0, 1'b0, 1'b0);
    repeat (3) send_ev(CMD_SAMPLE, 13'd0, 14'd5000, 1'b0, 1'b0);
    send_ev(CMD_SAMPLE, 13'd0, 14'd5000, 1'b0, 1'b1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        s_idle = 26;
        m_idle = 55;
      end else if (phase < 4) begin
        s_idle = 55;
        m_idle = 26;
      end else begin
        s_idle = 0;
        m_idle = 0;
      end
      case (phase)
        0: set_config(4500, 50, 14'd1, 2000);
        1: set_config(0, 0, 14'd0, 0);
        2: set_config(16383, 255, 14'h3fff, 16383);
        3: set_config($urandom_range(6000, 3000), $urandom_range(16383),
                      14'($urandom_range(16383)), $urandom_range(5000));
        4: set_config(4800, 255, 14'h3ffe, 4000);
        default: set_config($urandom_range(6000, 3000), $urandom_range(255),
                            14'($urandom_range(1)), $urandom_range(5000));
      endcase
      repeat (125) send_random();
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== input_current_limit_ramp.f =====
+incdir+sv
sv/icl_pkg.sv
sv/icl_step.sv
sv/input_current_limit_ramp.sv
tb/icl_ramp_checker.sv
tb/tb.sv
